// File: hdl/isw_pkg.sv
// Shared types and codes for the insertion sort word store.
// No dependencies; used by every module of the block.
package isw_pkg;

  // Command field of an input word.
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_POP    = 1'b1;

  // Chunk width in bits.
  localparam int unsigned CHUNK_W = 64;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_WORD  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // Per-cycle control broadcast to every cell of the chain.
  typedef struct packed {
    logic ins;  // insert finished word at its sorted place
    logic pop;  // shift everything one cell toward the head
  } cell_ctrl_t;

endpackage

// File: hdl/insertion_sort_words_unit.sv
// Top level of the insertion sort word store: chunk assembly, a chain of
// sorted cells and the result register. Depends on isw_pkg, isw_asm, isw_cell.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------------
//  in      | to block  | in_valid_i/in_stall_o | cmd_i, chunk_data_i, chunk_last_i
//  out     | from block| out_valid_o/out_stall_i| out_chunk_o, out_last_o, out_status_o
//
// Insert chunks are taken one per cycle while no result is pending; a finishing
// chunk places the word in the chain in that same cycle (every cell compares and
// shifts at once). A pop moves the head word into the result register and
// shifts the chain; its CHUNKS results then leave one per cycle while
// out_stall_i is low, and the input stalls until the last result of a word
// has been taken.
// Empty and full reports are single results and stall the input likewise.
// Reset clears the count, the assembly buffer and the result valid and status;
// the cell contents and the result word are not reset, only cells below the
// count are ever read.
module insertion_sort_words_unit #(
  parameter int unsigned MAX_WORDS  = 64,
  parameter int unsigned WORD_BYTES = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // input words
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        cmd_i,
  input  logic [isw_pkg::CHUNK_W-1:0] chunk_data_i,
  input  logic                        chunk_last_i,
  // result words
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [isw_pkg::CHUNK_W-1:0] out_chunk_o,
  output logic                        out_last_o,
  output logic [1:0]                  out_status_o
);

  localparam int unsigned Chunks = (WORD_BYTES + 7) / 8;
  localparam int unsigned WordW  = Chunks * isw_pkg::CHUNK_W;
  localparam int unsigned IdxW   = (Chunks > 1) ? $clog2(Chunks) : 1;
  localparam int unsigned CntW   = $clog2(MAX_WORDS + 1);

  // Handshakes
  logic in_fire;
  logic out_fire;
  logic take_ins;
  logic take_pop;

  assign in_fire  = in_valid_i && !in_stall_o;
  assign out_fire = out_valid_o && !out_stall_i;
  assign take_ins = in_fire && (cmd_i == isw_pkg::CMD_INSERT);
  assign take_pop = in_fire && (cmd_i == isw_pkg::CMD_POP);

  // Word assembly
  logic             asm_done;
  logic [WordW-1:0] new_word;

  isw_asm #(
    .WordBytes(WORD_BYTES)
  ) u_asm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .take_i (take_ins),
    .data_i (chunk_data_i),
    .last_i (chunk_last_i),
    .done_o (asm_done),
    .word_o (new_word)
  );

  // Occupancy
  logic [CntW-1:0] count_q;
  logic            full;
  logic            empty;

  assign full  = (count_q == CntW'(MAX_WORDS));
  assign empty = (count_q == '0);

  isw_pkg::cell_ctrl_t ctrl;
  assign ctrl.ins = asm_done && !full;
  assign ctrl.pop = take_pop && !empty;

  // Sorted chain: cell 0 holds the smallest word.
  logic [WordW-1:0]     cell_word [MAX_WORDS];
  logic [MAX_WORDS-1:0] cell_gt;

  for (genvar i = 0; i < MAX_WORDS; i++) begin : g_cell
    logic [WordW-1:0] prev_word;
    logic             prev_gt;
    logic [WordW-1:0] next_word;

    if (i == 0) begin : g_head
      assign prev_word = new_word;
      assign prev_gt   = 1'b0;
    end else begin : g_body
      assign prev_word = cell_word[i-1];
      assign prev_gt   = cell_gt[i-1];
    end

    if (i == MAX_WORDS - 1) begin : g_tail
      assign next_word = cell_word[i];
    end else begin : g_mid
      assign next_word = cell_word[i+1];
    end

    isw_cell #(
      .WordW(WordW)
    ) u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .occupied_i  (count_q > CntW'(i)),
      .new_word_i  (new_word),
      .prev_word_i (prev_word),
      .prev_gt_i   (prev_gt),
      .next_word_i (next_word),
      .word_o      (cell_word[i]),
      .gt_o        (cell_gt[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (ctrl.ins) begin
      count_q <= count_q + CntW'(1);
    end else if (ctrl.pop) begin
      count_q <= count_q - CntW'(1);
    end
  end

  // Result register: one word is sent out chunk by chunk, top chunk first.
  logic             out_valid_q;
  logic [IdxW-1:0]  out_left_q;
  isw_pkg::status_e out_status_q;
  logic [WordW-1:0] out_word_q;
  logic             new_result;

  assign new_result = take_pop || (asm_done && full);
  assign in_stall_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      out_left_q   <= '0;
      out_status_q <= isw_pkg::ST_WORD;
    end else if (new_result) begin
      out_valid_q <= 1'b1;
      if (take_pop && !empty) begin
        out_left_q   <= IdxW'(Chunks - 1);
        out_status_q <= isw_pkg::ST_WORD;
      end else if (take_pop) begin
        out_left_q   <= '0;
        out_status_q <= isw_pkg::ST_EMPTY;
      end else begin
        out_left_q   <= '0;
        out_status_q <= isw_pkg::ST_FULL;
      end
    end else if (out_fire) begin
      if (out_left_q == '0) begin
        out_valid_q <= 1'b0;
      end else begin
        out_left_q <= out_left_q - IdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (new_result) begin
      out_word_q <= ctrl.pop ? cell_word[0] : '0;
    end else if (out_fire) begin
      out_word_q <= out_word_q << isw_pkg::CHUNK_W;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_chunk_o  = out_word_q[WordW-1 -: isw_pkg::CHUNK_W];
  assign out_last_o   = (out_left_q == '0);
  assign out_status_o = out_status_q;

endmodule

// File: hdl/isw_cell.sv
// One cell of the sorted chain: holds one stored word.
// Depends on isw_pkg.
module isw_cell #(
  parameter int unsigned WordW = 256
) (
  input  logic                clk_i,
  input  isw_pkg::cell_ctrl_t ctrl_i,
  input  logic                occupied_i,
  input  logic [WordW-1:0]    new_word_i,
  input  logic [WordW-1:0]    prev_word_i,
  input  logic                prev_gt_i,
  input  logic [WordW-1:0]    next_word_i,
  output logic [WordW-1:0]    word_o,
  output logic                gt_o
);

  logic [WordW-1:0] word_q;

  // An empty cell counts as larger than anything.
  assign gt_o   = !occupied_i || (word_q > new_word_i);
  assign word_o = word_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.pop) begin
      word_q <= next_word_i;
    end else if (ctrl_i.ins) begin
      if (prev_gt_i) begin
        word_q <= prev_word_i;
      end else if (gt_o) begin
        word_q <= new_word_i;
      end
    end
  end

endmodule

// File: hdl/isw_asm.sv
// Collects incoming chunks into a whole word; flags the finishing chunk.
// Depends on isw_pkg.
module isw_asm #(
  parameter int unsigned WordBytes = 32
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          take_i,
  input  logic [isw_pkg::CHUNK_W-1:0]                   data_i,
  input  logic                                          last_i,
  output logic                                          done_o,
  output logic [((WordBytes+7)/8)*isw_pkg::CHUNK_W-1:0] word_o
);

  localparam int unsigned Chunks    = (WordBytes + 7) / 8;
  localparam int unsigned TailBytes = WordBytes - 8 * (Chunks - 1);
  localparam int unsigned IdxW      = (Chunks > 1) ? $clog2(Chunks) : 1;
  localparam logic [isw_pkg::CHUNK_W-1:0] TailMask =
    {isw_pkg::CHUNK_W{1'b1}} << (isw_pkg::CHUNK_W - 8 * TailBytes);

  // Element 0 is the most significant chunk.
  logic [0:Chunks-1][isw_pkg::CHUNK_W-1:0] buf_q;
  logic [0:Chunks-1][isw_pkg::CHUNK_W-1:0] word_c;
  logic [IdxW-1:0]                         idx_q;
  logic                                    at_tail;
  logic                                    fin;
  logic [isw_pkg::CHUNK_W-1:0]             data_m;

  assign at_tail = (idx_q == IdxW'(Chunks - 1));
  assign data_m  = at_tail ? (data_i & TailMask) : data_i;
  assign fin     = at_tail || last_i;
  assign done_o  = take_i && fin;

  // Entries past idx stay zero: cleared at every finish.
  always_comb begin
    word_c        = buf_q;
    word_c[idx_q] = data_m;
  end
  assign word_o = word_c;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_q <= '0;
      idx_q <= '0;
    end else if (take_i) begin
      if (fin) begin
        buf_q <= '0;
        idx_q <= '0;
      end else begin
        buf_q[idx_q] <= data_m;
        idx_q        <= idx_q + IdxW'(1);
      end
    end
  end

endmodule
